>>> hw/rtl/fmmt_pkg.sv
// ----------------------------------------------------------------------------
// fmmt_pkg
// Shared constants, codes and types of the single precision matrix product
// core with optional transposes.
// ----------------------------------------------------------------------------
package fmmt_pkg;

  // Largest accepted matrix dimension.
  localparam int MAX_DIM     = 16;
  // Word stores and their addressing.
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int WORD_W      = 32;
  // Dimension registers are five bits wide.
  localparam int DIM_W       = 5;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd6;

  localparam logic [WORD_W-1:0] ALPHA_RESET = 32'h3F80_0000;

  // Item operations.
  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_READ_C  = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIM   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Floating point unit operations.
  typedef enum logic {
    FOP_MUL = 1'b0,
    FOP_ADD = 1'b1
  } fop_t;

  // One request to the floating point unit.
  typedef struct packed {
    fop_t              fop;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } fpu_req_t;

endpackage

>>> hw/rtl/fmmt_ram.sv
// ----------------------------------------------------------------------------
// fmmt_ram
// Generic single port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module fmmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word each cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/fmmt_fpu.sv
// ----------------------------------------------------------------------------
// fmmt_fpu
// Two stage single precision multiply or add with round to nearest even.
// The first stage forms the exact product or aligned sum, the second stage
// normalizes and rounds.
// ----------------------------------------------------------------------------
module fmmt_fpu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  fmmt_pkg::fpu_req_t                  req,
  output logic                                vld,
  output logic [fmmt_pkg::WORD_W-1:0]         res
);
  import fmmt_pkg::*;

  localparam int MW = 51;
  localparam int XW = MW + 27;
  localparam logic [WORD_W-1:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [WORD_W-1:0] QUIET_BIT    = 32'h0040_0000;

  // Position of the leading one.
  function automatic logic [5:0] lead_pos(input logic [MW-1:0] v);
    logic [5:0] r;
    r = '0;
    for (int b = 0; b < MW; b++) begin
      if (v[b]) r = 6'(b);
    end
    return r;
  endfunction

  // Operand unpacking.
  logic       xs, ys, x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
  logic [7:0] xe, ye;
  logic [23:0] xm, ym;

  assign xs     = req.x[31];
  assign ys     = req.y[31];
  assign xe     = (req.x[30:23] == 8'd0) ? 8'd1 : req.x[30:23];
  assign ye     = (req.y[30:23] == 8'd0) ? 8'd1 : req.y[30:23];
  assign xm     = {req.x[30:23] != 8'd0, req.x[22:0]};
  assign ym     = {req.y[30:23] != 8'd0, req.y[22:0]};
  assign x_nan  = (req.x[30:23] == 8'hFF) && (req.x[22:0] != '0);
  assign y_nan  = (req.y[30:23] == 8'hFF) && (req.y[22:0] != '0);
  assign x_inf  = (req.x[30:23] == 8'hFF) && (req.x[22:0] == '0);
  assign y_inf  = (req.y[30:23] == 8'hFF) && (req.y[22:0] == '0);
  assign x_zero = (req.x[30:0] == '0);
  assign y_zero = (req.y[30:0] == '0);

  // Stage one: exact product or aligned sum and special cases.
  logic              s1_vld_r, s1_vld_nxt;
  logic              s1_spec_r, s1_spec_nxt;
  logic [WORD_W-1:0] s1_spec_val_r, s1_spec_val_nxt;
  logic              s1_sign_r, s1_sign_nxt;
  logic signed [11:0] s1_eadj_r, s1_eadj_nxt;
  logic [MW-1:0]     s1_m_r, s1_m_nxt;

  logic        x_big;
  logic [7:0]  big_e, sm_e, dexp;
  logic [23:0] big_m, sm_m;
  logic        big_s, sm_s;
  logic [49:0] sm_ext, sm_sh;
  logic        sm_lost;
  logic [MW-1:0] big_al, sm_al;

  always_comb begin
    x_big   = {xe, xm} >= {ye, ym};
    big_e   = x_big ? xe : ye;
    big_m   = x_big ? xm : ym;
    big_s   = x_big ? xs : ys;
    sm_e    = x_big ? ye : xe;
    sm_m    = x_big ? ym : xm;
    sm_s    = x_big ? ys : xs;
    dexp    = big_e - sm_e;
    sm_ext  = {sm_m, 26'd0};
    sm_sh   = sm_ext >> dexp;
    sm_lost = (sm_ext & ~({50{1'b1}} << dexp)) != '0;
    big_al  = {1'b0, big_m, 26'd0};
    sm_al   = {1'b0, sm_sh[49:1], sm_sh[0] | sm_lost};

    s1_vld_nxt      = go;
    s1_spec_nxt     = 1'b0;
    s1_spec_val_nxt = '0;
    if (req.fop == FOP_MUL) begin
      s1_m_nxt    = MW'(xm * ym);
      s1_sign_nxt = xs ^ ys;
      s1_eadj_nxt = $signed({4'd0, xe}) + $signed({4'd0, ye}) - 12'sd173;
      s1_spec_nxt = 1'b1;
      if (x_nan) begin
        s1_spec_val_nxt = req.x | QUIET_BIT;
      end else if (y_nan) begin
        s1_spec_val_nxt = req.y | QUIET_BIT;
      end else if ((x_inf && y_zero) || (y_inf && x_zero)) begin
        s1_spec_val_nxt = QNAN_DEFAULT;
      end else if (x_inf || y_inf) begin
        s1_spec_val_nxt = {xs ^ ys, 8'hFF, 23'd0};
      end else if (x_zero || y_zero) begin
        s1_spec_val_nxt = {xs ^ ys, 31'd0};
      end else begin
        s1_spec_nxt = 1'b0;
      end
    end else begin
      s1_m_nxt    = (big_s == sm_s) ? (big_al + sm_al) : (big_al - sm_al);
      s1_sign_nxt = (s1_m_nxt == '0) ? (xs & ys) : big_s;
      s1_eadj_nxt = $signed({4'd0, big_e}) - 12'sd49;
      s1_spec_nxt = 1'b1;
      if (x_nan) begin
        s1_spec_val_nxt = req.x | QUIET_BIT;
      end else if (y_nan) begin
        s1_spec_val_nxt = req.y | QUIET_BIT;
      end else if (x_inf && y_inf && (xs != ys)) begin
        s1_spec_val_nxt = QNAN_DEFAULT;
      end else if (x_inf) begin
        s1_spec_val_nxt = req.x;
      end else if (y_inf) begin
        s1_spec_val_nxt = req.y;
      end else begin
        s1_spec_nxt = 1'b0;
      end
    end
  end

  // Stage two: normalize, round and pack.
  logic [5:0]         p;
  logic signed [11:0] e_full, rs, shamt;
  logic               sub;
  logic [XW-1:0]      xw, yw;
  logic               lost, g, st, up;
  logic [23:0]        q;
  logic [7:0]         ef;
  logic [30:0]        packed_mag;
  logic [WORD_W-1:0]  res_nxt;

  always_comb begin
    p          = lead_pos(s1_m_r);
    e_full     = $signed({6'd0, p}) + s1_eadj_r;
    sub        = e_full < 12'sd1;
    rs         = sub ? (-12'sd22 - s1_eadj_r) : ($signed({6'd0, p}) - 12'sd23);
    shamt      = rs + 12'sd25;
    xw         = {s1_m_r, 27'd0};
    yw         = xw >> unsigned'(shamt);
    lost       = (xw & ~({XW{1'b1}} << unsigned'(shamt))) != '0;
    q          = yw[25:2];
    g          = yw[1];
    st         = yw[0] | lost;
    up         = g & (st | q[0]);
    ef         = sub ? 8'd0 : e_full[7:0];
    packed_mag = {ef, q[22:0]} + 31'(up);
    if (s1_spec_r) begin
      res_nxt = s1_spec_val_r;
    end else if (s1_m_r == '0) begin
      res_nxt = {s1_sign_r, 31'd0};
    end else if (!sub && (e_full >= 12'sd255)) begin
      res_nxt = {s1_sign_r, 8'hFF, 23'd0};
    end else begin
      res_nxt = {s1_sign_r, packed_mag};
    end
  end

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      vld      <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      vld      <= s1_vld_r;
    end
    s1_spec_r     <= s1_spec_nxt;
    s1_spec_val_r <= s1_spec_val_nxt;
    s1_sign_r     <= s1_sign_nxt;
    s1_eadj_r     <= s1_eadj_nxt;
    s1_m_r        <= s1_m_nxt;
    res           <= res_nxt;
  end

endmodule

>>> hw/rtl/float_matrix_multiply_transpose_core.sv
// A load returns its result word in the next cycle; a read of C goes through
// the registered C store read and the S_RDC state. A compute paces each
// multiply-add step by the fetch from the A and B memories and three passes
// through the two stage floating point unit. One item is in work at a time.
// Reset (synchronous, active low) restores the register defaults and marks C
// empty; the A, B and C memories are not cleared.
// ----------------------------------------------------------------------------
// float_matrix_multiply_transpose_core
// Single precision C = alpha * op(A) * op(B) with row-major word stores.
// ----------------------------------------------------------------------------
module float_matrix_multiply_transpose_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fmmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fmmt_pkg::WORD_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic [fmmt_pkg::ADDR_W-1:0]        in_index,
  input  logic [fmmt_pkg::WORD_W-1:0]        in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fmmt_pkg::WORD_W-1:0]        out_data,
  output logic [1:0]                         out_status
);
  import fmmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RDC, S_FETCH, S_MUL1, S_W1, S_W2, S_W3
  } state_t;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (32'(d) <= 32'(MAX_DIM));
  endfunction

  // Registers.
  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [DIM_W-1:0]  a_rows_nxt, a_cols_nxt, b_rows_nxt, b_cols_nxt;
  logic              trans_a_r, trans_b_r, trans_a_nxt, trans_b_nxt;
  logic [WORD_W-1:0] alpha_r, alpha_nxt;
  logic [DIM_W-1:0]  i_r, j_r, p_r, m_r, n_r, k_r;
  logic [DIM_W-1:0]  i_nxt, j_nxt, p_nxt, m_nxt, n_nxt, k_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt, b_val_r, b_val_nxt;
  logic [CNT_W-1:0]  c_count_r, c_count_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;
  status_t           out_status_r, out_status_nxt;

  // Memory and unit controls.
  logic              a_we, b_we, c_we;
  logic [ADDR_W-1:0] a_addr, b_addr, c_addr;
  logic [WORD_W-1:0] a_rdata, b_rdata, c_rdata, c_wdata;
  logic              fpu_go, fpu_vld;
  fpu_req_t          fpu_req;
  logic [WORD_W-1:0] fpu_res;

  // Geometry derived from the registers.
  logic [DIM_W-1:0]  mm, kk, k2, nn;
  logic [PROD_W-1:0] a_sz, b_sz, mn_sz, ia, ib, ic;
  logic              geom_ok, in_acc, last_p, last_j, last_i;

  assign mm      = trans_a_r ? a_cols_r : a_rows_r;
  assign kk      = trans_a_r ? a_rows_r : a_cols_r;
  assign k2      = trans_b_r ? b_cols_r : b_rows_r;
  assign nn      = trans_b_r ? b_rows_r : b_cols_r;
  assign a_sz    = PROD_W'(a_rows_r) * PROD_W'(a_cols_r);
  assign b_sz    = PROD_W'(b_rows_r) * PROD_W'(b_cols_r);
  assign mn_sz   = PROD_W'(mm) * PROD_W'(nn);
  assign geom_ok = dim_ok(a_rows_r) && dim_ok(a_cols_r) && dim_ok(b_rows_r) &&
                   dim_ok(b_cols_r) && (a_sz <= PROD_W'(STORE_DEPTH)) &&
                   (b_sz <= PROD_W'(STORE_DEPTH)) && (kk == k2) &&
                   (mn_sz <= PROD_W'(STORE_DEPTH));

  // Element addresses of the current step.
  assign ia = trans_a_r ? (PROD_W'(p_r) * PROD_W'(a_cols_r) + PROD_W'(i_r))
                        : (PROD_W'(i_r) * PROD_W'(a_cols_r) + PROD_W'(p_r));
  assign ib = trans_b_r ? (PROD_W'(j_r) * PROD_W'(b_cols_r) + PROD_W'(p_r))
                        : (PROD_W'(p_r) * PROD_W'(b_cols_r) + PROD_W'(j_r));
  assign ic = PROD_W'(i_r) * PROD_W'(n_r) + PROD_W'(j_r);

  assign last_p = (p_r == k_r - DIM_W'(1));
  assign last_j = (j_r == n_r - DIM_W'(1));
  assign last_i = (i_r == m_r - DIM_W'(1));

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE) && (!out_vld_r || out_ready);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_vld_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;

  // Next state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    a_rows_nxt     = a_rows_r;
    a_cols_nxt     = a_cols_r;
    b_rows_nxt     = b_rows_r;
    b_cols_nxt     = b_cols_r;
    trans_a_nxt    = trans_a_r;
    trans_b_nxt    = trans_b_r;
    alpha_nxt      = alpha_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    p_nxt          = p_r;
    m_nxt          = m_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    b_val_nxt      = b_val_r;
    c_count_nxt    = c_count_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    a_we           = 1'b0;
    b_we           = 1'b0;
    c_we           = 1'b0;
    a_addr         = in_index;
    b_addr         = in_index;
    c_addr         = in_index;
    c_wdata        = fpu_res;
    fpu_go         = 1'b0;
    fpu_req        = '{fop: FOP_MUL, x: alpha_r, y: a_rdata};

    // Register writes.
    if (cfg_valid) begin
      case (cfg_index)
        CFG_A_ROWS:  a_rows_nxt  = cfg_data[DIM_W-1:0];
        CFG_A_COLS:  a_cols_nxt  = cfg_data[DIM_W-1:0];
        CFG_B_ROWS:  b_rows_nxt  = cfg_data[DIM_W-1:0];
        CFG_B_COLS:  b_cols_nxt  = cfg_data[DIM_W-1:0];
        CFG_TRANS_A: trans_a_nxt = cfg_data[0];
        CFG_TRANS_B: trans_b_nxt = cfg_data[0];
        CFG_ALPHA:   alpha_nxt   = cfg_data;
        default:     ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_data_nxt   = '0;
          out_status_nxt = ST_OK;
          case (op_t'(in_op))
            OP_LOAD_A: begin
              out_vld_nxt = 1'b1;
              if (PROD_W'(in_index) < a_sz) a_we = 1'b1;
              else out_status_nxt = ST_RANGE;
            end
            OP_LOAD_B: begin
              out_vld_nxt = 1'b1;
              if (PROD_W'(in_index) < b_sz) b_we = 1'b1;
              else out_status_nxt = ST_RANGE;
            end
            OP_COMPUTE: begin
              if (geom_ok) begin
                m_nxt     = mm;
                n_nxt     = nn;
                k_nxt     = kk;
                i_nxt     = '0;
                j_nxt     = '0;
                p_nxt     = '0;
                acc_nxt   = '0;
                state_nxt = S_FETCH;
              end else begin
                out_vld_nxt    = 1'b1;
                out_status_nxt = ST_DIM;
              end
            end
            OP_READ_C: begin
              if (CNT_W'(in_index) < c_count_r) begin
                state_nxt = S_RDC;
              end else begin
                out_vld_nxt    = 1'b1;
                out_status_nxt = ST_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDC: begin
        out_vld_nxt    = 1'b1;
        out_data_nxt   = c_rdata;
        out_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
      end
      S_FETCH: begin
        a_addr    = ia[ADDR_W-1:0];
        b_addr    = ib[ADDR_W-1:0];
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        // Scale the A element while the B element waits.
        fpu_go    = 1'b1;
        b_val_nxt = b_rdata;
        state_nxt = S_W1;
      end
      S_W1: begin
        fpu_req = '{fop: FOP_MUL, x: fpu_res, y: b_val_r};
        if (fpu_vld) begin
          fpu_go    = 1'b1;
          state_nxt = S_W2;
        end
      end
      S_W2: begin
        fpu_req = '{fop: FOP_ADD, x: acc_r, y: fpu_res};
        if (fpu_vld) begin
          fpu_go    = 1'b1;
          state_nxt = S_W3;
        end
      end
      S_W3: begin
        if (fpu_vld) begin
          acc_nxt   = fpu_res;
          p_nxt     = p_r + DIM_W'(1);
          state_nxt = S_FETCH;
          if (last_p) begin
            // Element finished: store it and move to the next one.
            c_we    = 1'b1;
            c_addr  = ic[ADDR_W-1:0];
            acc_nxt = '0;
            p_nxt   = '0;
            j_nxt   = j_r + DIM_W'(1);
            if (last_j) begin
              j_nxt = '0;
              i_nxt = i_r + DIM_W'(1);
              if (last_i) begin
                c_count_nxt    = CNT_W'(PROD_W'(m_r) * PROD_W'(n_r));
                out_vld_nxt    = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = ST_OK;
                state_nxt      = S_IDLE;
              end
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      a_rows_r  <= DIM_W'(1);
      a_cols_r  <= DIM_W'(1);
      b_rows_r  <= DIM_W'(1);
      b_cols_r  <= DIM_W'(1);
      trans_a_r <= 1'b0;
      trans_b_r <= 1'b0;
      alpha_r   <= ALPHA_RESET;
      c_count_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      a_rows_r  <= a_rows_nxt;
      a_cols_r  <= a_cols_nxt;
      b_rows_r  <= b_rows_nxt;
      b_cols_r  <= b_cols_nxt;
      trans_a_r <= trans_a_nxt;
      trans_b_r <= trans_b_nxt;
      alpha_r   <= alpha_nxt;
      c_count_r <= c_count_nxt;
      out_vld_r <= out_vld_nxt;
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    p_r          <= p_nxt;
    m_r          <= m_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    acc_r        <= acc_nxt;
    b_val_r      <= b_val_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  // Matrix stores.
  fmmt_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_a_ram (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(in_value), .rdata(a_rdata)
  );
  fmmt_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_b_ram (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(in_value), .rdata(b_rdata)
  );
  fmmt_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_c_ram (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
  );

  // Shared multiply and add unit.
  fmmt_fpu u_fpu (
    .clk(clk), .rst_n(rst_n), .go(fpu_go), .req(fpu_req),
    .vld(fpu_vld), .res(fpu_res)
  );

`ifndef SYNTHESIS
  // The unit only answers while a step waits for it.
  a_fpu_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    fpu_vld |-> (state_r == S_W1 || state_r == S_W2 || state_r == S_W3))
    else $error("unit result outside a compute step");

  // A read of C always delivers its word in the following cycle.
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDC) |=> (out_vld_r && state_r == S_IDLE))
    else $error("read of C did not complete");

  // The count of valid C words never exceeds the store.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    c_count_r <= CNT_W'(STORE_DEPTH))
    else $error("C count out of range");

  // C is only written while a compute is running.
  a_c_write: assert property (@(posedge clk) disable iff (!rst_n)
    c_we |-> (state_r == S_W3 && fpu_vld))
    else $error("unexpected write to C");
`endif

endmodule

>>> tb/tb_float_matrix_multiply_transpose_core.sv
// ----------------------------------------------------------------------------
// Regression bench for the single precision matrix product core
// Loads A and B, runs computes under many shapes, transposes and scale
// factors, and reads C back. Every result word is checked against an
// in-bench bit-exact float32 model with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_float_matrix_multiply_transpose_core;
  import fmmt_pkg::*;

  typedef enum {STEP_WORD, STEP_REG, STEP_DRAIN} step_kind_e;

  typedef struct {
    step_kind_e         kind;
    op_t                op;
    logic [7:0]         idx;
    logic [31:0]        val;
    logic [2:0]         reg_idx;
  } stim_t;

  typedef struct {
    logic [31:0] data;
    status_t     status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [7:0]  in_index = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_data;
  logic [1:0]  out_status;

  float_matrix_multiply_transpose_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_index(in_index), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stim_t   pending_q[$];
  result_t results_q[$];
  int      failures = 0;

  // Shadow of the core's registers and stores.
  logic [4:0]  m_a_rows, m_a_cols, m_b_rows, m_b_cols;
  logic        m_trans_a, m_trans_b;
  logic [31:0] m_alpha;
  logic [31:0] m_a[256];
  logic [31:0] m_b[256];
  logic [31:0] m_c[256];
  int unsigned m_c_count;

  // Round a nonzero value sig * 2^e2 to float32, nearest even.
  function automatic logic [31:0] fp_round(bit s, int e2, logic [63:0] sig);
    int          be;
    int          sh;
    logic [63:0] t;
    logic [31:0] r;
    bit          inc;
    while (!sig[63]) begin
      sig = sig << 1;
      e2--;
    end
    be = e2 + 63 + 127;
    if (be >= 255) return {s, 8'hFF, 23'd0};
    if (be < 1) begin
      sh = 1 - be;
      if (sh > 63) begin
        sig = 64'd1;
      end else begin
        t = sig;
        sig = sig >> sh;
        if ((t & ((64'd1 << sh) - 64'd1)) != 0) sig[0] = 1'b1;
      end
      be = 0;
    end
    inc = sig[39] && ((sig[38:0] != 0) || sig[40]);
    if (be == 0) r = {8'd0, sig[63:40]} + {31'd0, inc};
    else r = {1'b0, be[7:0], sig[62:40]} + {31'd0, inc};
    r[31] = s;
    return r;
  endfunction

  function automatic bit is_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 0;
  endfunction

  function automatic logic [63:0] fp_sig(logic [31:0] x);
    return (x[30:23] == 0) ? {41'd0, x[22:0]} : {40'd0, 1'b1, x[22:0]};
  endfunction

  function automatic int fp_exp(logic [31:0] x);
    return (x[30:23] == 0) ? 1 : int'(x[30:23]);
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] x, logic [31:0] y);
    bit s;
    s = x[31] ^ y[31];
    if (is_nan(x)) return x | 32'h0040_0000;
    if (is_nan(y)) return y | 32'h0040_0000;
    if (is_inf(x) || is_inf(y)) begin
      if (x[30:0] == 0 || y[30:0] == 0) return 32'hFFC0_0000;
      return {s, 8'hFF, 23'd0};
    end
    if (x[30:0] == 0 || y[30:0] == 0) return {s, 31'd0};
    return fp_round(s, fp_exp(x) + fp_exp(y) - 300, fp_sig(x) * fp_sig(y));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] x, logic [31:0] y);
    logic [31:0] big;
    logic [31:0] tiny;
    logic [63:0] sl;
    logic [63:0] ss;
    logic [63:0] sum;
    int          d;
    if (is_nan(x)) return x | 32'h0040_0000;
    if (is_nan(y)) return y | 32'h0040_0000;
    if (is_inf(x) && is_inf(y) && x[31] != y[31]) return 32'hFFC0_0000;
    if (is_inf(x)) return x;
    if (is_inf(y)) return y;
    if (x[30:0] == 0 && y[30:0] == 0) return {x[31] & y[31], 31'd0};
    if (x[30:0] == 0) return y;
    if (y[30:0] == 0) return x;
    if (x[30:0] >= y[30:0]) begin
      big = x;
      tiny = y;
    end else begin
      big = y;
      tiny = x;
    end
    sl = fp_sig(big) << 39;
    ss = fp_sig(tiny) << 39;
    d = fp_exp(big) - fp_exp(tiny);
    // Align the smaller operand and keep what falls off as a sticky bit.
    if (d > 63) begin
      ss = 64'd1;
    end else if (d > 0) begin
      sum = ss;
      ss = ss >> d;
      if ((sum & ((64'd1 << d) - 64'd1)) != 0) ss[0] = 1'b1;
    end
    if (big[31] == tiny[31]) sum = sl + ss;
    else sum = sl - ss;
    if (sum == 0) return 32'd0;
    return fp_round(big[31], fp_exp(big) - 150 - 39, sum);
  endfunction

  function automatic bit dim_fits(logic [4:0] d);
    return d >= 1 && d <= MAX_DIM;
  endfunction

  // C = alpha * op(A) * op(B) on the shadow stores.
  function automatic status_t product_status();
    int unsigned m, k, k2, n, ia, ib;
    logic [31:0] acc;
    logic [31:0] t;
    if (!dim_fits(m_a_rows) || !dim_fits(m_a_cols) || !dim_fits(m_b_rows) ||
        !dim_fits(m_b_cols)) return ST_DIM;
    m  = m_trans_a ? m_a_cols : m_a_rows;
    k  = m_trans_a ? m_a_rows : m_a_cols;
    k2 = m_trans_b ? m_b_cols : m_b_rows;
    n  = m_trans_b ? m_b_rows : m_b_cols;
    if (k != k2 || m * n > STORE_DEPTH) return ST_DIM;
    for (int unsigned i = 0; i < m; i++) begin
      for (int unsigned j = 0; j < n; j++) begin
        acc = 32'd0;
        for (int unsigned p = 0; p < k; p++) begin
          ia = m_trans_a ? (p * m_a_cols + i) : (i * m_a_cols + p);
          ib = m_trans_b ? (j * m_b_cols + p) : (p * m_b_cols + j);
          t = fp_mul(m_alpha, m_a[ia % 256]);
          t = fp_mul(t, m_b[ib % 256]);
          acc = fp_add(acc, t);
        end
        m_c[(i * n + j) % 256] = acc;
      end
    end
    m_c_count = m * n;
    return ST_OK;
  endfunction

  function automatic result_t predict_word(op_t op, logic [7:0] idx, logic [31:0] val);
    result_t r;
    r.data = 32'd0;
    r.status = ST_OK;
    case (op)
      OP_LOAD_A: begin
        if (int'(idx) < int'(m_a_rows) * int'(m_a_cols)) m_a[idx] = val;
        else r.status = ST_RANGE;
      end
      OP_LOAD_B: begin
        if (int'(idx) < int'(m_b_rows) * int'(m_b_cols)) m_b[idx] = val;
        else r.status = ST_RANGE;
      end
      OP_COMPUTE: r.status = product_status();
      default: begin
        if (idx < m_c_count) r.data = m_c[idx];
        else r.status = ST_RANGE;
      end
    endcase
    return r;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      CFG_A_ROWS:  m_a_rows = data[4:0];
      CFG_A_COLS:  m_a_cols = data[4:0];
      CFG_B_ROWS:  m_b_rows = data[4:0];
      CFG_B_COLS:  m_b_cols = data[4:0];
      CFG_TRANS_A: m_trans_a = data[0];
      CFG_TRANS_B: m_trans_b = data[0];
      CFG_ALPHA:   m_alpha = data;
      default: ;
    endcase
  endfunction

  // Driver: one word or one register write at a time from the pending queue.
  int gap_cnt = 0;
  int settle_cnt = 0;

  always @(posedge clk) begin
    bit      hold;
    bit      nv;
    bit      ncv;
    stim_t   s;
    result_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      m_a_rows = 5'd1;
      m_a_cols = 5'd1;
      m_b_rows = 5'd1;
      m_b_cols = 5'd1;
      m_trans_a = 1'b0;
      m_trans_b = 1'b0;
      m_alpha = ALPHA_RESET;
      m_c_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        r = predict_word(op_t'(in_op), in_index, in_value);
        results_q.push_back(r);
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      hold = (in_valid && !in_ready) || (cfg_valid && !cfg_ready);
      if (!hold) begin
        nv = 1'b0;
        ncv = 1'b0;
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pending_q.size() != 0) begin
          s = pending_q[0];
          if (s.kind == STEP_WORD) begin
            void'(pending_q.pop_front());
            nv = 1'b1;
            in_op <= s.op;
            in_index <= s.idx;
            in_value <= s.val;
            if (pending_q.size() > 150 && $urandom_range(0, 7) == 0)
              gap_cnt = $urandom_range(1, 18);
          end else if (results_q.size() == 0 && settle_cnt >= 4) begin
            // The core is idle: registers may change, or the pause ends.
            void'(pending_q.pop_front());
            settle_cnt = 0;
            if (s.kind == STEP_REG) begin
              ncv = 1'b1;
              cfg_index <= s.reg_idx;
              cfg_data <= s.val;
            end
          end else if (results_q.size() == 0) begin
            settle_cnt++;
          end else begin
            settle_cnt = 0;
          end
        end
        in_valid <= nv;
        cfg_valid <= ncv;
      end
    end
  end

  // Monitor: random stalls, one long hold-off, and the result check.
  int stall_cnt = 0;
  int hold_cnt = 0;
  int words_seen = 0;

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (results_q.size() == 0) begin
          $error("unexpected result word: data %h status %0d", out_data, out_status);
          failures++;
        end else begin
          e = results_q.pop_front();
          if (out_data !== e.data) begin
            $error("data mismatch: expected %h actual %h", e.data, out_data);
            failures++;
          end
          if (out_status !== e.status) begin
            $error("status mismatch: expected %0d actual %0d", e.status, out_status);
            failures++;
          end
        end
        if (words_seen == 400) hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else if (pending_q.size() > 150 && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus building.
  int word_total = 0;

  task automatic add_word(op_t op, logic [7:0] idx, logic [31:0] val);
    stim_t s;
    s.kind = STEP_WORD;
    s.op = op;
    s.idx = idx;
    s.val = val;
    s.reg_idx = '0;
    pending_q.push_back(s);
    word_total++;
  endtask

  task automatic add_reg(logic [2:0] idx, logic [31:0] data);
    stim_t s;
    s.kind = STEP_REG;
    s.op = OP_LOAD_A;
    s.idx = '0;
    s.val = data;
    s.reg_idx = idx;
    pending_q.push_back(s);
  endtask

  task automatic add_drain();
    stim_t s;
    s.kind = STEP_DRAIN;
    s.op = OP_LOAD_A;
    s.idx = '0;
    s.val = '0;
    s.reg_idx = '0;
    pending_q.push_back(s);
  endtask

  // Mostly ordinary numbers, with zeros, infinities, NaNs and subnormals.
  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 15))
      0: v[30:0] = '0;
      1: v[30:0] = {8'hFF, 23'd0};
      2: v[30:23] = 8'hFF;
      3: v[30:23] = 8'h00;
      4: v[30:0] = 31'h7F7F_FFFF;
      5: ;
      default: v[30:23] = 8'($urandom_range(112, 140));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_scale();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: v = ALPHA_RESET;
      1: v = rand_float();
      default: v[30:23] = 8'($urandom_range(120, 134));
    endcase
    return v;
  endfunction

  // One phase: registers, full loads of A and B, a compute, reads and noise.
  task automatic run_phase(int ar, int ac, int br, int bc, bit ta, bit tb,
                           logic [31:0] scale, int noise);
    int m, k, k2, n, na, nb, nc;
    add_reg(CFG_A_ROWS, 32'(ar));
    add_reg(CFG_A_COLS, 32'(ac));
    add_reg(CFG_B_ROWS, 32'(br));
    add_reg(CFG_B_COLS, 32'(bc));
    add_reg(CFG_TRANS_A, 32'(ta));
    add_reg(CFG_TRANS_B, 32'(tb));
    add_reg(CFG_ALPHA, scale);
    na = (ar * ac > 256) ? 256 : ar * ac;
    nb = (br * bc > 256) ? 256 : br * bc;
    for (int i = 0; i < na; i++) add_word(OP_LOAD_A, 8'(i), rand_float());
    for (int i = 0; i < nb; i++) add_word(OP_LOAD_B, 8'(i), rand_float());
    if (na < 256) add_word(OP_LOAD_A, 8'($urandom_range(na, 255)), $urandom());
    if (nb < 256) add_word(OP_LOAD_B, 8'($urandom_range(nb, 255)), $urandom());
    add_word(OP_COMPUTE, 8'($urandom()), $urandom());
    m = ta ? ac : ar;
    k = ta ? ar : ac;
    k2 = tb ? bc : br;
    n = tb ? br : bc;
    nc = (ar >= 1 && ar <= 16 && ac >= 1 && ac <= 16 && br >= 1 && br <= 16 &&
          bc >= 1 && bc <= 16 && k == k2) ? m * n : 4;
    for (int i = 0; i < nc; i++) add_word(OP_READ_C, 8'(i), $urandom());
    if (nc < 256) add_word(OP_READ_C, 8'(nc), $urandom());
    for (int i = 0; i < noise; i++) begin
      case ($urandom_range(0, 5))
        0: add_word(OP_LOAD_A, 8'($urandom()), rand_float());
        1: add_word(OP_LOAD_B, 8'($urandom()), rand_float());
        2: add_word(OP_COMPUTE, 8'($urandom()), $urandom());
        default: add_word(OP_READ_C, 8'($urandom()), $urandom());
      endcase
    end
  endtask

  initial begin
    int  m, k, n, sel, big_phases;
    bit  ta, tb;
    big_phases = 0;

    // Directed: reset shape, read before compute, range edges, extremes.
    add_word(OP_READ_C, 8'd0, 32'd0);
    add_word(OP_LOAD_A, 8'd1, 32'hFFFF_FFFF);
    add_word(OP_LOAD_A, 8'd255, 32'h1234_5678);
    add_word(OP_LOAD_B, 8'd255, 32'h0);
    add_word(OP_LOAD_A, 8'd0, 32'h7F7F_FFFF);
    add_word(OP_LOAD_B, 8'd0, 32'h0000_0001);
    add_word(OP_COMPUTE, 8'd0, 32'd0);
    add_word(OP_READ_C, 8'd0, 32'd0);
    add_word(OP_READ_C, 8'd1, 32'd0);
    add_word(OP_LOAD_B, 8'd0, 32'hFF80_0000);
    add_word(OP_COMPUTE, 8'hFF, 32'hFFFF_FFFF);
    add_word(OP_READ_C, 8'd0, 32'd0);
    add_reg(3'd7, 32'hFFFF_FFFF);
    // Zero dimension, oversized dimension and inner size mismatch.
    run_phase(0, 3, 3, 2, 1'b0, 1'b0, ALPHA_RESET, 0);
    run_phase(17, 2, 2, 31, 1'b0, 1'b0, ALPHA_RESET, 0);
    run_phase(2, 3, 2, 2, 1'b0, 1'b0, 32'hBF80_0000, 0);
    // Largest shape with both transposes, and a NaN scale factor.
    run_phase(16, 16, 16, 16, 1'b1, 1'b1, rand_scale(), 2);
    run_phase(2, 2, 2, 2, 1'b0, 1'b1, 32'h7FC0_0001, 0);
    add_drain();

    // Random phases: mostly consistent shapes with random content.
    while (word_total < 2000) begin
      sel = $urandom_range(0, 19);
      ta = $urandom_range(0, 1);
      tb = $urandom_range(0, 1);
      m = $urandom_range(1, 4);
      k = $urandom_range(1, 4);
      n = $urandom_range(1, 4);
      if (sel == 3) begin
        m = $urandom_range(1, 8);
        k = $urandom_range(1, 8);
        n = $urandom_range(1, 8);
      end
      if (sel == 2 && big_phases < 1) begin
        m = 16;
        k = 16;
        n = 16;
        big_phases++;
      end
      if (sel == 0) begin
        run_phase($urandom_range(0, 31), $urandom_range(0, 5), $urandom_range(0, 5),
                  $urandom_range(0, 31), ta, tb, rand_scale(), 3);
      end else begin
        if (sel == 1) k = k + 1;
        run_phase(ta ? k : m, ta ? m : k, tb ? n : ((sel == 1) ? k - 1 : k),
                  tb ? ((sel == 1) ? k - 1 : k) : n, ta, tb, rand_scale(),
                  $urandom_range(0, 6));
      end
      if ($urandom_range(0, 9) == 0) add_drain();
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || cfg_valid || results_q.size() != 0);
    repeat (20) @(posedge clk);
    if (failures == 0 && results_q.size() == 0) begin
      $display("float_matrix_multiply_transpose_core regression: pass");
    end else begin
      $display("float_matrix_multiply_transpose_core regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("float_matrix_multiply_transpose_core regression: fail");
    $finish;
  end

endmodule
